// ----- hw/rtl/cc20_pkg.sv -----
// cc20_pkg: shared types, constants and round helpers for the ChaCha20 keystream XOR block
// depends on nothing; imported by every module of the block

package cc20_pkg;

    // number of double rounds per keystream block
    localparam int DOUBLE_ROUNDS = 10;
    localparam int NUM_ROUNDS    = 2 * DOUBLE_ROUNDS;
    localparam int RND_W         = $clog2(NUM_ROUNDS);

    // block constants "expand 32-byte k"
    localparam logic [31:0] SIGMA_0 = 32'h61707865;
    localparam logic [31:0] SIGMA_1 = 32'h3320646e;
    localparam logic [31:0] SIGMA_2 = 32'h79622d32;
    localparam logic [31:0] SIGMA_3 = 32'h6b206574;

    // register reset values (test key and nonce)
    localparam logic [63:0] KEY01_RST   = 64'h0706050403020100;
    localparam logic [63:0] KEY23_RST   = 64'h0f0e0d0c0b0a0908;
    localparam logic [63:0] KEY45_RST   = 64'h1716151413121110;
    localparam logic [63:0] KEY67_RST   = 64'h1f1e1d1c1b1a1918;
    localparam logic [63:0] NONCE01_RST = 64'h4a00000009000000;
    localparam logic [31:0] NONCE2_RST  = 32'h00000000;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    // item kinds
    typedef enum logic [1:0] {
        FN_BUILD = 2'd0,
        FN_ENC   = 2'd1,
        FN_DEC   = 2'd2
    } func_t;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY01   = 3'd0,
        CFG_KEY23   = 3'd1,
        CFG_KEY45   = 3'd2,
        CFG_KEY67   = 3'd3,
        CFG_NONCE01 = 3'd4,
        CFG_NONCE2  = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic [1:0]  func;
        logic [63:0] data_chunk;
        logic [2:0]  chunk_index;
        logic [3:0]  byte_count;
        logic        first_chunk;
        logic        last_chunk;
        logic [31:0] counter_in;
    } in_item_t;

    typedef struct packed {
        logic [63:0] data_out;
        logic [31:0] counter_out;
    } out_item_t;

    // controller to datapath
    typedef struct packed {
        logic cap_item;
        logic cnt_load;
        logic cnt_inc;
        logic init_work;
        logic do_round;
        logic do_add;
        logic do_xor;
        logic emit;
    } cc20_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [1:0] func;
        logic       first_chunk;
        logic       last_chunk;
        logic       round_last;
    } cc20_stat_t;

    typedef logic [31:0] word_t;

    function automatic word_t rotl(input word_t x, input int unsigned n);
        return (x << n) | (x >> (32 - n));
    endfunction

    // one quarter round, result packed as {a, b, c, d}
    function automatic logic [127:0] qround(input word_t a_in, input word_t b_in,
                                            input word_t c_in, input word_t d_in);
        word_t a;
        word_t b;
        word_t c;
        word_t d;
        a = a_in; b = b_in; c = c_in; d = d_in;
        a = a + b; d = rotl(d ^ a, 16);
        c = c + d; b = rotl(b ^ c, 12);
        a = a + b; d = rotl(d ^ a, 8);
        c = c + d; b = rotl(b ^ c, 7);
        return {a, b, c, d};
    endfunction

endpackage

// ----- hw/rtl/chacha20_keystream_xor_top.sv -----
// ChaCha20 keystream XOR block, top level: one item at a time. A chunk that needs no
// new keystream goes from acceptance through its xor and emit steps back to idle, where the
// next transaction can be taken. A build item runs init, the rounds of all DOUBLE_ROUNDS
// double rounds, add and emit. A chunk that rebuilds the keystream (last encrypt chunk, first
// decrypt chunk) runs the same build steps plus an xor step: before the build for encrypt,
// after it for decrypt. The shared round unit runs one column or diagonal round per cycle.
// The unused item kind goes straight to its emit step. s_ready is high only while the block is idle; a finished
// result waits in the output register until taken, and the next item then holds in its
// emit step. Key and nonce registers are written through cfg_wr_en/cfg_index/cfg_wdata;
// the user must write them only while the block is idle, the block does not enforce this.
// depends on cc20_pkg, cc20_ctrl, cc20_dp

module chacha20_keystream_xor_top
    import cc20_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_data
);

    cc20_cmd_t  cmd;
    cc20_stat_t stat;

    // sequencer
    cc20_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // datapath
    cc20_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_data    (s_data),
        .m_data    (m_data),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

// ----- hw/rtl/cc20_ctrl.sv -----
// cc20_ctrl: sequencing state machine for the ChaCha20 keystream XOR block
// depends on cc20_pkg; drives cc20_dp through the command struct

module cc20_ctrl
    import cc20_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  in_item_t   s_data,
    output logic       m_valid,
    input  logic       m_ready,
    input  cc20_stat_t stat,
    output cc20_cmd_t  cmd
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_INIT  = 6'b000010,
        ST_ROUND = 6'b000100,
        ST_ADD   = 6'b001000,
        ST_XOR   = 6'b010000,
        ST_EMIT  = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   accept;
    logic   out_free;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;

    // next state and commands
    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cmd.cap_item = 1'b1;
                    case (s_data.func)
                        FN_BUILD: state_next = ST_INIT;
                        FN_ENC:   state_next = ST_XOR;
                        FN_DEC: begin
                            if (s_data.first_chunk) begin
                                cmd.cnt_load = 1'b1;
                                state_next   = ST_INIT;
                            end else begin
                                state_next = ST_XOR;
                            end
                        end
                        default:  state_next = ST_EMIT;
                    endcase
                end
            end
            ST_INIT: begin
                cmd.init_work = 1'b1;
                state_next    = ST_ROUND;
            end
            ST_ROUND: begin
                cmd.do_round = 1'b1;
                if (stat.round_last) begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD: begin
                cmd.do_add = 1'b1;
                // decrypt rebuilds before its xor, the others are done
                state_next = (stat.func == FN_DEC) ? ST_XOR : ST_EMIT;
            end
            ST_XOR: begin
                cmd.do_xor = 1'b1;
                if (stat.func == FN_ENC && stat.last_chunk) begin
                    cmd.cnt_inc = 1'b1;
                    state_next  = ST_INIT;
                end else begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    cmd.emit     = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // state and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// ----- hw/rtl/cc20_dp.sv -----
// cc20_dp: datapath of the ChaCha20 keystream XOR block: registers, round unit, xor
// depends on cc20_pkg; controlled by cc20_ctrl

module cc20_dp
    import cc20_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  in_item_t              s_data,
    output out_item_t             m_data,
    input  cc20_cmd_t             cmd,
    output cc20_stat_t            stat
);

    logic [63:0] key01_reg, key23_reg, key45_reg, key67_reg, nonce01_reg;
    logic [31:0] nonce2_reg;
    logic [31:0] cnt_reg, cnt_next;
    logic [RND_W-1:0] rnd_reg;
    in_item_t    item_reg;
    word_t       work_reg [16];
    word_t       work_next [16];
    word_t       ks_reg [16];
    word_t       init_w [16];
    logic [63:0] res_reg;
    logic [63:0] ks_row;
    logic [63:0] xor_mask;
    out_item_t   out_reg;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key01_reg   <= KEY01_RST;
            key23_reg   <= KEY23_RST;
            key45_reg   <= KEY45_RST;
            key67_reg   <= KEY67_RST;
            nonce01_reg <= NONCE01_RST;
            nonce2_reg  <= NONCE2_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_KEY01:   key01_reg   <= cfg_wdata;
                CFG_KEY23:   key23_reg   <= cfg_wdata;
                CFG_KEY45:   key45_reg   <= cfg_wdata;
                CFG_KEY67:   key67_reg   <= cfg_wdata;
                CFG_NONCE01: nonce01_reg <= cfg_wdata;
                CFG_NONCE2:  nonce2_reg  <= cfg_wdata[31:0];
                default: ;
            endcase
        end
    end

    // input block state
    always_comb begin
        init_w[0]  = SIGMA_0;
        init_w[1]  = SIGMA_1;
        init_w[2]  = SIGMA_2;
        init_w[3]  = SIGMA_3;
        init_w[4]  = key01_reg[31:0];
        init_w[5]  = key01_reg[63:32];
        init_w[6]  = key23_reg[31:0];
        init_w[7]  = key23_reg[63:32];
        init_w[8]  = key45_reg[31:0];
        init_w[9]  = key45_reg[63:32];
        init_w[10] = key67_reg[31:0];
        init_w[11] = key67_reg[63:32];
        init_w[12] = cnt_reg;
        init_w[13] = nonce01_reg[31:0];
        init_w[14] = nonce01_reg[63:32];
        init_w[15] = nonce2_reg;
    end

    // block counter
    always_comb begin
        cnt_next = cnt_reg;
        if (cmd.cnt_load) begin
            cnt_next = s_data.counter_in;
        end else if (cmd.cnt_inc) begin
            cnt_next = cnt_reg + 32'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            rnd_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
            if (cmd.init_work) begin
                rnd_reg <= '0;
            end else if (cmd.do_round) begin
                rnd_reg <= rnd_reg + RND_W'(1);
            end
        end
    end

    // one round per cycle: column round on even steps, diagonal on odd;
    // the diagonal round rotates row r left by r, runs the column round, rotates back
    always_comb begin
        word_t       p [16];
        logic [127:0] q;
        logic [1:0]  sh;
        for (int r = 0; r < 4; r++) begin
            sh = rnd_reg[0] ? 2'(r) : 2'd0;
            for (int i = 0; i < 4; i++) begin
                p[{2'(r), 2'(i)}] = work_reg[{2'(r), 2'(i) + sh}];
            end
        end
        for (int i = 0; i < 4; i++) begin
            q = qround(p[i], p[4 + i], p[8 + i], p[12 + i]);
            p[i]      = q[127:96];
            p[4 + i]  = q[95:64];
            p[8 + i]  = q[63:32];
            p[12 + i] = q[31:0];
        end
        for (int r = 0; r < 4; r++) begin
            sh = rnd_reg[0] ? 2'(r) : 2'd0;
            for (int i = 0; i < 4; i++) begin
                work_next[{2'(r), 2'(i) + sh}] = p[{2'(r), 2'(i)}];
            end
        end
    end

    // working state and keystream block
    always_ff @(posedge aclk) begin
        for (int k = 0; k < 16; k++) begin
            if (cmd.init_work) begin
                work_reg[k] <= init_w[k];
            end else if (cmd.do_round) begin
                work_reg[k] <= work_next[k];
            end
            if (cmd.do_add) begin
                ks_reg[k] <= work_reg[k] + init_w[k];
            end
        end
    end

    // keystream slice and byte mask
    assign ks_row = {ks_reg[{item_reg.chunk_index, 1'b1}],
                     ks_reg[{item_reg.chunk_index, 1'b0}]};

    always_comb begin
        for (int b = 0; b < 8; b++) begin
            xor_mask[8*b +: 8] = (4'(b) < item_reg.byte_count) ? 8'hff : 8'h00;
        end
    end

    // captured item, result and output register
    always_ff @(posedge aclk) begin
        if (cmd.cap_item) begin
            item_reg <= s_data;
            res_reg  <= '0;
        end else if (cmd.do_xor) begin
            res_reg <= item_reg.data_chunk ^ (ks_row & xor_mask);
        end
        if (cmd.emit) begin
            out_reg.data_out    <= res_reg;
            out_reg.counter_out <= cnt_reg;
        end
    end

    assign m_data          = out_reg;
    assign stat.func       = item_reg.func;
    assign stat.first_chunk = item_reg.first_chunk;
    assign stat.last_chunk = item_reg.last_chunk;
    assign stat.round_last = (rnd_reg == RND_W'(NUM_ROUNDS - 1));

endmodule

// ----- hw/rtl/cc20_chk.sv -----
// cc20_chk: port-level assertions for the ChaCha20 keystream XOR block, bound to the top
// depends on cc20_pkg and chacha20_keystream_xor_top

module cc20_chk
    import cc20_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_valid,
    input logic                  s_ready,
    input logic                  m_valid,
    input logic                  m_ready,
    input out_item_t             m_data
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // one transaction at a time: input closes after an accept
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input still open after accept");

    // a new result comes exactly as the block returns to idle
    a_emit_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $rose(s_ready))
        else $error("result raised without returning to idle");

    // reset empties the output and leaves the block idle
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("reset state wrong");

endmodule

bind chacha20_keystream_xor_top cc20_chk u_chk (.*);
